### rtl/oct_pkg.sv
// Shared types and constants for the oven cooking timer controller.
package oct_pkg;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_WEIGHT = 3'd1,
        PH_READY  = 3'd2,
        PH_COOK   = 3'd3,
        PH_PAUSE  = 3'd4,
        PH_DONE   = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        MSG_NONE    = 3'd0,
        MSG_POPCORN = 3'd1,
        MSG_BEEF    = 3'd2,
        MSG_CHICKEN = 3'd3,
        MSG_START   = 3'd4,
        MSG_ERROR   = 3'd5,
        MSG_WRONG   = 3'd6
    } msg_t;

    typedef enum logic [1:0] {
        ACT_KEY   = 2'd0,
        ACT_START = 2'd1,
        ACT_PAUSE = 2'd2,
        ACT_TICK  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        FOOD_NONE    = 2'd0,
        FOOD_POPCORN = 2'd1,
        FOOD_BEEF    = 2'd2,
        FOOD_CHICKEN = 2'd3
    } food_t;

    localparam logic [1:0] CFG_POPCORN = 2'd0;
    localparam logic [1:0] CFG_BEEF    = 2'd1;
    localparam logic [1:0] CFG_CHICKEN = 2'd2;

    localparam int SEC_W  = 10;
    localparam int RATE_W = 6;
    localparam int WGT_W  = 4;
    localparam int KEY_W  = 8;

    localparam logic [SEC_W-1:0]  POPCORN_RESET = 10'd60;
    localparam logic [RATE_W-1:0] BEEF_RESET    = 6'd30;
    localparam logic [RATE_W-1:0] CHICKEN_RESET = 6'd12;
    localparam logic [SEC_W-1:0]  SEC_MAX       = 10'd1023;

    localparam logic [KEY_W-1:0] KEY_A    = 8'h41;
    localparam logic [KEY_W-1:0] KEY_B    = 8'h42;
    localparam logic [KEY_W-1:0] KEY_C    = 8'h43;
    localparam logic [KEY_W-1:0] KEY_ZERO = 8'h30;
    localparam logic [KEY_W-1:0] KEY_ONE  = 8'h31;
    localparam logic [KEY_W-1:0] KEY_NINE = 8'h39;

    typedef struct packed {
        phase_t             phase;
        logic [SEC_W-1:0]   seconds;
        logic               half;
        food_t              food;
        logic               lamp;
        logic               buzzer;
        logic [WGT_W-1:0]   weight;
    } timer_state_t;

    typedef struct packed {
        logic [SEC_W-1:0]  popcorn;
        logic [RATE_W-1:0] beef;
        logic [RATE_W-1:0] chicken;
    } timer_cfg_t;

endpackage

### rtl/oct_step.sv
// Next-state and message logic for one timer request.
module oct_step #(
    parameter int DONE_TOGGLES = 4,
    parameter int TOG_W        = 3
) (
    input  oct_pkg::timer_state_t cur,
    input  logic [TOG_W-1:0]      cur_tog,
    input  oct_pkg::timer_cfg_t   cfg,
    input  logic [1:0]            action,
    input  logic [7:0]            key_code,
    input  logic                  door_closed,
    output oct_pkg::timer_state_t nxt,
    output logic [TOG_W-1:0]      nxt_tog,
    output oct_pkg::msg_t         msg
);

    logic [oct_pkg::KEY_W-1:0]  digit_full;
    logic [oct_pkg::WGT_W-1:0]  digit;
    logic [oct_pkg::RATE_W-1:0] rate;
    logic [oct_pkg::SEC_W-1:0]  product;
    logic                       digit_ok;

    assign digit_full = key_code - oct_pkg::KEY_ZERO;
    assign digit      = digit_full[oct_pkg::WGT_W-1:0];
    assign digit_ok   = (key_code >= oct_pkg::KEY_ONE) && (key_code <= oct_pkg::KEY_NINE);
    assign rate       = (cur.food == oct_pkg::FOOD_BEEF) ? cfg.beef : cfg.chicken;
    assign product    = {{(oct_pkg::SEC_W-oct_pkg::RATE_W){1'b0}}, rate}
                      * {{(oct_pkg::SEC_W-oct_pkg::WGT_W){1'b0}}, digit};

    always_comb
    begin
        logic [oct_pkg::SEC_W-1:0] dec;
        nxt     = cur;
        nxt_tog = cur_tog;
        msg     = oct_pkg::MSG_NONE;
        dec     = cur.seconds;
        case (oct_pkg::action_t'(action))
            oct_pkg::ACT_KEY:
            begin
                if (cur.phase == oct_pkg::PH_IDLE && door_closed)
                begin
                    nxt.weight = '0;
                    if (key_code == oct_pkg::KEY_A)
                    begin
                        nxt.food    = oct_pkg::FOOD_POPCORN;
                        nxt.seconds = cfg.popcorn;
                        nxt.phase   = oct_pkg::PH_READY;
                        msg         = oct_pkg::MSG_POPCORN;
                    end
                    else if (key_code == oct_pkg::KEY_B)
                    begin
                        nxt.food  = oct_pkg::FOOD_BEEF;
                        nxt.phase = oct_pkg::PH_WEIGHT;
                        msg       = oct_pkg::MSG_BEEF;
                    end
                    else if (key_code == oct_pkg::KEY_C)
                    begin
                        nxt.food  = oct_pkg::FOOD_CHICKEN;
                        nxt.phase = oct_pkg::PH_WEIGHT;
                        msg       = oct_pkg::MSG_CHICKEN;
                    end
                    else
                    begin
                        msg = oct_pkg::MSG_WRONG;
                    end
                end
                else if (cur.phase == oct_pkg::PH_WEIGHT)
                begin
                    if (digit_ok)
                    begin
                        nxt.weight  = digit;
                        nxt.seconds = product;
                        nxt.phase   = oct_pkg::PH_READY;
                        msg         = oct_pkg::MSG_START;
                    end
                    else
                    begin
                        nxt     = '0;
                        nxt_tog = '0;
                        msg     = oct_pkg::MSG_ERROR;
                    end
                end
            end
            oct_pkg::ACT_START:
            begin
                if (door_closed && (cur.phase == oct_pkg::PH_READY ||
                                    cur.phase == oct_pkg::PH_PAUSE))
                begin
                    if (cur.seconds == '0)
                    begin
                        nxt.phase   = oct_pkg::PH_DONE;
                        nxt.seconds = '0;
                        nxt.half    = 1'b0;
                        nxt.lamp    = 1'b1;
                        nxt.buzzer  = 1'b0;
                        nxt_tog     = '0;
                    end
                    else
                    begin
                        nxt.phase = oct_pkg::PH_COOK;
                        nxt.lamp  = 1'b1;
                        nxt.half  = 1'b0;
                    end
                end
            end
            oct_pkg::ACT_PAUSE:
            begin
                if (cur.phase == oct_pkg::PH_COOK)
                begin
                    nxt.phase = oct_pkg::PH_PAUSE;
                    nxt.half  = 1'b0;
                end
                else if (cur.phase == oct_pkg::PH_PAUSE)
                begin
                    nxt     = '0;
                    nxt_tog = '0;
                end
            end
            oct_pkg::ACT_TICK:
            begin
                if (cur.phase == oct_pkg::PH_COOK)
                begin
                    nxt.half = ~cur.half;
                    if (cur.half)
                    begin
                        if (cur.seconds != '0)
                            dec = cur.seconds - 1'b1;
                        nxt.seconds = dec;
                        if (dec == '0)
                        begin
                            nxt.phase   = oct_pkg::PH_DONE;
                            nxt.seconds = '0;
                            nxt.half    = 1'b0;
                            nxt.lamp    = 1'b1;
                            nxt.buzzer  = 1'b0;
                            nxt_tog     = '0;
                        end
                    end
                end
                else if (cur.phase == oct_pkg::PH_PAUSE)
                begin
                    nxt.lamp = ~cur.lamp;
                end
                else if (cur.phase == oct_pkg::PH_DONE)
                begin
                    if (cur_tog < TOG_W'(DONE_TOGGLES))
                    begin
                        nxt.lamp   = ~cur.lamp;
                        nxt.buzzer = ~cur.buzzer;
                        nxt_tog    = cur_tog + 1'b1;
                    end
                    else
                    begin
                        nxt     = '0;
                        nxt_tog = '0;
                    end
                end
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

endmodule

### rtl/oven_cooking_timer_controller.sv
// Oven cooking timer controller: state, configuration and result registers.
// Latency: a result is valid in the cycle after its request is accepted.
// Throughput: one request per cycle, unless a held result with out_ready low stalls in_ready.
// The result register takes the next request while the previous one drains.
// Reset (rst_n low, asynchronous): idle, all counts and outputs cleared,
// configuration back to 60 s popcorn, 30 s/kg beef, 12 s/kg chicken.
module oven_cooking_timer_controller #(
    parameter int DONE_TOGGLES = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [9:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic [7:0]  key_code,
    input  logic        door_closed,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  phase,
    output logic [9:0]  seconds_left,
    output logic        lamps_on,
    output logic        buzzer_on,
    output logic [2:0]  message,
    output logic [3:0]  weight_shown
);

    localparam int TOG_W = $clog2(DONE_TOGGLES + 1);

    oct_pkg::timer_state_t state_reg;
    oct_pkg::timer_state_t state_next;
    logic [TOG_W-1:0]      tog_reg;
    logic [TOG_W-1:0]      tog_next;
    oct_pkg::timer_cfg_t   cfg_reg;
    oct_pkg::msg_t         msg_next;
    logic                  out_valid_reg;
    oct_pkg::timer_state_t res_reg;
    oct_pkg::msg_t         msg_reg;
    logic                  accept;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    oct_step #(
        .DONE_TOGGLES (DONE_TOGGLES),
        .TOG_W        (TOG_W)
    ) u_step (
        .cur         (state_reg),
        .cur_tog     (tog_reg),
        .cfg         (cfg_reg),
        .action      (action),
        .key_code    (key_code),
        .door_closed (door_closed),
        .nxt         (state_next),
        .nxt_tog     (tog_next),
        .msg         (msg_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.popcorn <= oct_pkg::POPCORN_RESET;
            cfg_reg.beef    <= oct_pkg::BEEF_RESET;
            cfg_reg.chicken <= oct_pkg::CHICKEN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                oct_pkg::CFG_POPCORN: cfg_reg.popcorn <= cfg_data;
                oct_pkg::CFG_BEEF:    cfg_reg.beef    <= cfg_data[oct_pkg::RATE_W-1:0];
                oct_pkg::CFG_CHICKEN: cfg_reg.chicken <= cfg_data[oct_pkg::RATE_W-1:0];
                default:              cfg_reg         <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            tog_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                state_reg <= state_next;
                tog_reg   <= tog_next;
            end
            if (accept)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg <= '0;
            msg_reg <= oct_pkg::MSG_NONE;
        end
        else if (accept)
        begin
            res_reg <= state_next;
            msg_reg <= msg_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign phase        = res_reg.phase;
    assign seconds_left = res_reg.seconds;
    assign lamps_on     = res_reg.lamp;
    assign buzzer_on    = res_reg.buzzer;
    assign message      = msg_reg;
    assign weight_shown = res_reg.weight;

`ifndef SYNTHESIS
    a_cook_lamp: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase == oct_pkg::PH_COOK |-> state_reg.lamp)
        else $error("lamps off while cooking");

    a_buzzer_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.buzzer |-> state_reg.phase == oct_pkg::PH_DONE)
        else $error("buzzer on outside done phase");

    a_tog_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tog_reg <= TOG_W'(DONE_TOGGLES))
        else $error("toggle count beyond limit");

    a_weight_phase: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.weight != '0 |->
            (state_reg.phase != oct_pkg::PH_IDLE && state_reg.phase != oct_pkg::PH_WEIGHT))
        else $error("weight held in idle or weight entry");

    a_hold_state: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(state_reg) && $stable(tog_reg))
        else $error("state changed without a request");
`endif

endmodule

### dv/testbench.sv
// Testbench for the oven cooking timer controller: directed table, random sessions, scoreboard.
`timescale 1ns / 100ps

module testbench;

    localparam int DONE_TOGGLES = 4;
    localparam logic [oct_pkg::KEY_W-1:0] KEY_D      = 8'h44;
    localparam logic [1:0]                CFG_UNUSED = 2'd3;

    typedef struct packed {
        oct_pkg::action_t          act;
        logic [oct_pkg::KEY_W-1:0] key;
        logic                      door;
    } request_t;

    typedef struct packed {
        oct_pkg::phase_t           phase;
        logic [oct_pkg::SEC_W-1:0] secs;
        logic                      lamp;
        logic                      buzz;
        oct_pkg::msg_t             msg;
        logic [oct_pkg::WGT_W-1:0] weight;
    } display_t;

    typedef struct {
        bit         is_cfg;
        logic [1:0] reg_idx;
        logic [9:0] reg_val;
        request_t   req;
        bit         typed;
        display_t   want;
    } step_row_t;

    logic             clk;
    logic             rst_n = 1'b0;
    logic             cfg_we = 1'b0;
    logic [1:0]       cfg_index = '0;
    logic [9:0]       cfg_data = '0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    logic [1:0]       action = '0;
    logic [7:0]       key_code = '0;
    logic             door_closed = 1'b0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    logic [2:0]       phase;
    logic [9:0]       seconds_left;
    logic             lamps_on;
    logic             buzzer_on;
    logic [2:0]       message;
    logic [3:0]       weight_shown;

    // timer model state and its copy of the registers
    oct_pkg::phase_t            st_phase   = oct_pkg::PH_IDLE;
    logic [oct_pkg::SEC_W-1:0]  st_secs    = '0;
    logic                       st_half    = 1'b0;
    oct_pkg::food_t             st_food    = oct_pkg::FOOD_NONE;
    int                         st_toggles = 0;
    logic                       st_lamp    = 1'b0;
    logic                       st_buzz    = 1'b0;
    logic [oct_pkg::WGT_W-1:0]  st_weight  = '0;
    logic [oct_pkg::SEC_W-1:0]  cfg_popcorn      = oct_pkg::POPCORN_RESET;
    logic [oct_pkg::RATE_W-1:0] cfg_beef_rate    = oct_pkg::BEEF_RESET;
    logic [oct_pkg::RATE_W-1:0] cfg_chicken_rate = oct_pkg::CHICKEN_RESET;

    display_t  expected_q[$];
    step_row_t steps[$];
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;
    int accepted       = 0;
    int results_seen   = 0;
    int reg_writes     = 0;
    int done_entries   = 0;
    int errors         = 0;

    oven_cooking_timer_controller #(.DONE_TOGGLES(DONE_TOGGLES)) DUT (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

    function automatic void clear_state();
        st_phase   = oct_pkg::PH_IDLE;
        st_secs    = '0;
        st_half    = 1'b0;
        st_food    = oct_pkg::FOOD_NONE;
        st_toggles = 0;
        st_lamp    = 1'b0;
        st_buzz    = 1'b0;
        st_weight  = '0;
    endfunction

    function automatic void enter_done();
        st_phase   = oct_pkg::PH_DONE;
        st_secs    = '0;
        st_half    = 1'b0;
        st_toggles = 0;
        st_lamp    = 1'b1;
        st_buzz    = 1'b0;
        done_entries++;
    endfunction

    function automatic display_t advance_timer(request_t req);
        display_t      d;
        oct_pkg::msg_t m;
        int            digit;
        int            rate;
        int            t;
        m = oct_pkg::MSG_NONE;
        case (req.act)
            oct_pkg::ACT_KEY:
            begin
                if (st_phase == oct_pkg::PH_IDLE && req.door)
                begin
                    st_weight = '0;
                    if (req.key == oct_pkg::KEY_A)
                    begin
                        st_food  = oct_pkg::FOOD_POPCORN;
                        st_secs  = cfg_popcorn;
                        st_phase = oct_pkg::PH_READY;
                        m        = oct_pkg::MSG_POPCORN;
                    end
                    else if (req.key == oct_pkg::KEY_B)
                    begin
                        st_food  = oct_pkg::FOOD_BEEF;
                        st_phase = oct_pkg::PH_WEIGHT;
                        m        = oct_pkg::MSG_BEEF;
                    end
                    else if (req.key == oct_pkg::KEY_C)
                    begin
                        st_food  = oct_pkg::FOOD_CHICKEN;
                        st_phase = oct_pkg::PH_WEIGHT;
                        m        = oct_pkg::MSG_CHICKEN;
                    end
                    else
                        m = oct_pkg::MSG_WRONG;
                end
                else if (st_phase == oct_pkg::PH_WEIGHT)
                begin
                    if (req.key >= oct_pkg::KEY_ONE && req.key <= oct_pkg::KEY_NINE)
                    begin
                        digit = int'(req.key) - int'(oct_pkg::KEY_ZERO);
                        rate  = (st_food == oct_pkg::FOOD_BEEF) ? int'(cfg_beef_rate)
                                                                : int'(cfg_chicken_rate);
                        t     = digit * rate;
                        if (t > int'(oct_pkg::SEC_MAX))
                            t = int'(oct_pkg::SEC_MAX);
                        st_weight = digit[oct_pkg::WGT_W-1:0];
                        st_secs   = t[oct_pkg::SEC_W-1:0];
                        st_phase  = oct_pkg::PH_READY;
                        m         = oct_pkg::MSG_START;
                    end
                    else
                    begin
                        clear_state();
                        m = oct_pkg::MSG_ERROR;
                    end
                end
            end
            oct_pkg::ACT_START:
            begin
                if (req.door && (st_phase == oct_pkg::PH_READY ||
                                 st_phase == oct_pkg::PH_PAUSE))
                begin
                    if (st_secs == 0)
                        enter_done();
                    else
                    begin
                        st_phase = oct_pkg::PH_COOK;
                        st_lamp  = 1'b1;
                        st_half  = 1'b0;
                    end
                end
            end
            oct_pkg::ACT_PAUSE:
            begin
                if (st_phase == oct_pkg::PH_COOK)
                begin
                    st_phase = oct_pkg::PH_PAUSE;
                    st_half  = 1'b0;
                end
                else if (st_phase == oct_pkg::PH_PAUSE)
                    clear_state();
            end
            default:
            begin
                if (st_phase == oct_pkg::PH_COOK)
                begin
                    st_half = ~st_half;
                    if (!st_half)
                    begin
                        if (st_secs > 0)
                            st_secs--;
                        if (st_secs == 0)
                            enter_done();
                    end
                end
                else if (st_phase == oct_pkg::PH_PAUSE)
                    st_lamp = ~st_lamp;
                else if (st_phase == oct_pkg::PH_DONE)
                begin
                    if (st_toggles < DONE_TOGGLES)
                    begin
                        st_lamp    = ~st_lamp;
                        st_buzz    = ~st_buzz;
                        st_toggles = (st_toggles + 1) & 7;
                    end
                    else
                        clear_state();
                end
            end
        endcase
        d.phase  = st_phase;
        d.secs   = st_secs;
        d.lamp   = st_lamp;
        d.buzz   = st_buzz;
        d.msg    = m;
        d.weight = st_weight;
        return d;
    endfunction

    function automatic request_t req_of(oct_pkg::action_t a, logic [oct_pkg::KEY_W-1:0] k,
                                        logic door);
        request_t r;
        r.act  = a;
        r.key  = k;
        r.door = door;
        return r;
    endfunction

    task automatic tbl_ev(oct_pkg::action_t a, logic [oct_pkg::KEY_W-1:0] k, logic door);
        step_row_t row;
        row        = '{default: '0};
        row.req    = req_of(a, k, door);
        steps.push_back(row);
    endtask

    task automatic tbl_typed(oct_pkg::action_t a, logic [oct_pkg::KEY_W-1:0] k, logic door,
                             oct_pkg::phase_t p, int s, logic l, logic b, oct_pkg::msg_t m,
                             int w);
        step_row_t row;
        row             = '{default: '0};
        row.req         = req_of(a, k, door);
        row.typed       = 1'b1;
        row.want.phase  = p;
        row.want.secs   = s[oct_pkg::SEC_W-1:0];
        row.want.lamp   = l;
        row.want.buzz   = b;
        row.want.msg    = m;
        row.want.weight = w[oct_pkg::WGT_W-1:0];
        steps.push_back(row);
    endtask

    task automatic tbl_cfg(logic [1:0] idx, logic [9:0] val);
        step_row_t row;
        row         = '{default: '0};
        row.is_cfg  = 1'b1;
        row.reg_idx = idx;
        row.reg_val = val;
        steps.push_back(row);
    endtask

    task automatic report_mismatch(string what);
        $display("mismatch: %s", what);
        errors++;
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                      results_seen, name, got, want));
    endtask

    task automatic send_req(request_t req, bit typed = 1'b0, display_t want = '0);
        display_t d;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        action      <= req.act;
        key_code    <= req.key;
        door_closed <= req.door;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        d = advance_timer(req);
        expected_q.push_back(typed ? want : d);
        accepted++;
    endtask

    task automatic wait_drain();
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [9:0] val);
        in_valid <= 1'b0;
        wait_drain();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            oct_pkg::CFG_POPCORN: cfg_popcorn      = val;
            oct_pkg::CFG_BEEF:    cfg_beef_rate    = val[oct_pkg::RATE_W-1:0];
            oct_pkg::CFG_CHICKEN: cfg_chicken_rate = val[oct_pkg::RATE_W-1:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic send_noise();
        send_req(req_of(oct_pkg::action_t'($urandom_range(3)), 8'($urandom_range(255)),
                        1'($urandom_range(1))));
    endtask

    task automatic back_to_idle();
        while (st_phase != oct_pkg::PH_IDLE)
        begin
            case (st_phase)
                oct_pkg::PH_WEIGHT:
                    send_req(req_of(oct_pkg::ACT_KEY, oct_pkg::KEY_A, 1'($urandom_range(1))));
                oct_pkg::PH_READY:
                    send_req(req_of(oct_pkg::ACT_START, 8'($urandom_range(255)), 1'b1));
                oct_pkg::PH_COOK, oct_pkg::PH_PAUSE:
                    send_req(req_of(oct_pkg::ACT_PAUSE, 8'($urandom_range(255)), 1'b1));
                default:
                    send_req(req_of(oct_pkg::ACT_TICK, 8'($urandom_range(255)), 1'b1));
            endcase
        end
    endtask

    // one well-formed cooking request sequence, with some abuse mixed in
    task automatic cook_session();
        int                        food;
        int                        budget;
        int                        n;
        int                        r;
        logic [oct_pkg::KEY_W-1:0] k;
        back_to_idle();
        food = $urandom_range(2);
        if ($urandom_range(9) == 0)
            send_req(req_of(oct_pkg::ACT_KEY, oct_pkg::KEY_A + 8'(food), 1'b0));
        send_req(req_of(oct_pkg::ACT_KEY, oct_pkg::KEY_A + 8'(food), 1'b1));
        if (st_phase == oct_pkg::PH_WEIGHT)
        begin
            if ($urandom_range(9) == 0)
            begin
                do
                    k = 8'($urandom_range(255));
                while (k >= oct_pkg::KEY_ONE && k <= oct_pkg::KEY_NINE);
            end
            else
                k = oct_pkg::KEY_ONE + 8'($urandom_range(8));
            send_req(req_of(oct_pkg::ACT_KEY, k, 1'($urandom_range(1))));
            if (st_phase != oct_pkg::PH_READY)
                return;
        end
        if ($urandom_range(6) == 0)
            send_req(req_of(oct_pkg::ACT_START, 8'($urandom_range(255)), 1'b0));
        send_req(req_of(oct_pkg::ACT_START, 8'($urandom_range(255)), 1'b1));
        budget = $urandom_range(10, 70);
        for (n = 0; n < budget && st_phase != oct_pkg::PH_IDLE; n++)
        begin
            r = $urandom_range(99);
            if (r < 4)
                send_req(req_of(oct_pkg::ACT_PAUSE, 8'($urandom_range(255)),
                                1'($urandom_range(1))));
            else if (r < 8 && st_phase == oct_pkg::PH_PAUSE)
                send_req(req_of(oct_pkg::ACT_START, 8'($urandom_range(255)),
                                $urandom_range(9) != 0));
            else if (r < 11)
                send_req(req_of(oct_pkg::ACT_KEY, 8'($urandom_range(255)),
                                1'($urandom_range(1))));
            else
                send_req(req_of(oct_pkg::ACT_TICK, 8'($urandom_range(255)),
                                1'($urandom_range(1))));
        end
    endtask

    task automatic run_phase(int idle_pct, int stall_pct, int n);
        int stop_at;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        stop_at        = accepted + n;
        while (accepted < stop_at)
        begin
            if ($urandom_range(9) == 0)
                send_noise();
            else
                cook_session();
        end
    endtask

    // result side: scoreboard plus ready pattern, including the long hold-off
    initial
    begin
        display_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                results_seen++;
                if (expected_q.size() == 0)
                    report_mismatch($sformatf("result %0d arrived with nothing expected",
                                              results_seen));
                else
                begin
                    want = expected_q.pop_front();
                    check_field("phase", 32'(phase), 32'(want.phase));
                    check_field("seconds_left", 32'(seconds_left), 32'(want.secs));
                    check_field("lamps_on", 32'(lamps_on), 32'(want.lamp));
                    check_field("buzzer_on", 32'(buzzer_on), 32'(want.buzz));
                    check_field("message", 32'(message), 32'(want.msg));
                    check_field("weight_shown", 32'(weight_shown), 32'(want.weight));
                end
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        tbl_typed(oct_pkg::ACT_TICK, 8'h00, 1'b1, oct_pkg::PH_IDLE, 0, 1'b0, 1'b0,
                  oct_pkg::MSG_NONE, 0);
        tbl_typed(oct_pkg::ACT_KEY, oct_pkg::KEY_A, 1'b0, oct_pkg::PH_IDLE, 0, 1'b0, 1'b0,
                  oct_pkg::MSG_NONE, 0);
        tbl_typed(oct_pkg::ACT_KEY, KEY_D, 1'b1, oct_pkg::PH_IDLE, 0, 1'b0, 1'b0,
                  oct_pkg::MSG_WRONG, 0);
        tbl_typed(oct_pkg::ACT_START, 8'hFF, 1'b1, oct_pkg::PH_IDLE, 0, 1'b0, 1'b0,
                  oct_pkg::MSG_NONE, 0);
        tbl_typed(oct_pkg::ACT_PAUSE, 8'h00, 1'b1, oct_pkg::PH_IDLE, 0, 1'b0, 1'b0,
                  oct_pkg::MSG_NONE, 0);
        tbl_typed(oct_pkg::ACT_KEY, oct_pkg::KEY_B, 1'b1, oct_pkg::PH_WEIGHT, 0, 1'b0, 1'b0,
                  oct_pkg::MSG_BEEF, 0);
        tbl_typed(oct_pkg::ACT_KEY, oct_pkg::KEY_ZERO, 1'b0, oct_pkg::PH_IDLE, 0, 1'b0, 1'b0,
                  oct_pkg::MSG_ERROR, 0);
        tbl_typed(oct_pkg::ACT_KEY, oct_pkg::KEY_C, 1'b1, oct_pkg::PH_WEIGHT, 0, 1'b0, 1'b0,
                  oct_pkg::MSG_CHICKEN, 0);
        tbl_typed(oct_pkg::ACT_KEY, oct_pkg::KEY_NINE, 1'b0, oct_pkg::PH_READY, 108, 1'b0,
                  1'b0, oct_pkg::MSG_START, 9);
        tbl_ev(oct_pkg::ACT_KEY, oct_pkg::KEY_A, 1'b1);
        tbl_ev(oct_pkg::ACT_START, 8'h00, 1'b0);
        tbl_ev(oct_pkg::ACT_START, 8'h00, 1'b1);
        tbl_ev(oct_pkg::ACT_PAUSE, 8'hFF, 1'b1);
        tbl_ev(oct_pkg::ACT_TICK, 8'h00, 1'b0);
        tbl_typed(oct_pkg::ACT_PAUSE, 8'h00, 1'b0, oct_pkg::PH_IDLE, 0, 1'b0, 1'b0,
                  oct_pkg::MSG_NONE, 0);
        // zero popcorn time: start jumps straight to the done flashing
        tbl_cfg(oct_pkg::CFG_POPCORN, 10'd0);
        tbl_cfg(oct_pkg::CFG_BEEF, 10'd1);
        tbl_cfg(oct_pkg::CFG_CHICKEN, 10'h3FF);
        tbl_typed(oct_pkg::ACT_KEY, oct_pkg::KEY_A, 1'b1, oct_pkg::PH_READY, 0, 1'b0, 1'b0,
                  oct_pkg::MSG_POPCORN, 0);
        tbl_typed(oct_pkg::ACT_START, 8'h00, 1'b1, oct_pkg::PH_DONE, 0, 1'b1, 1'b0,
                  oct_pkg::MSG_NONE, 0);
        for (int i = 0; i < DONE_TOGGLES; i++)
            tbl_ev(oct_pkg::ACT_TICK, 8'h00, 1'b1);
        tbl_typed(oct_pkg::ACT_TICK, 8'h00, 1'b1, oct_pkg::PH_IDLE, 0, 1'b0, 1'b0,
                  oct_pkg::MSG_NONE, 0);
        tbl_ev(oct_pkg::ACT_KEY, oct_pkg::KEY_B, 1'b1);
        tbl_typed(oct_pkg::ACT_KEY, oct_pkg::KEY_ONE, 1'b1, oct_pkg::PH_READY, 1, 1'b0, 1'b0,
                  oct_pkg::MSG_START, 1);
        tbl_ev(oct_pkg::ACT_START, 8'h00, 1'b1);
        tbl_ev(oct_pkg::ACT_TICK, 8'h00, 1'b1);
        tbl_typed(oct_pkg::ACT_TICK, 8'h00, 1'b1, oct_pkg::PH_DONE, 0, 1'b1, 1'b0,
                  oct_pkg::MSG_NONE, 1);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (steps[i])
        begin
            if (steps[i].is_cfg)
                write_reg(steps[i].reg_idx, steps[i].reg_val);
            else
                send_req(steps[i].req, steps[i].typed, steps[i].want);
        end

        // short times so sessions finish; receiver holds off to back up the pipe
        write_reg(oct_pkg::CFG_POPCORN, 10'd5);
        write_reg(oct_pkg::CFG_BEEF, 10'd1);
        write_reg(oct_pkg::CFG_CHICKEN, 10'd2);
        hold_left = 48;
        run_phase(0, 0, 160);

        write_reg(oct_pkg::CFG_POPCORN, oct_pkg::SEC_MAX);
        write_reg(oct_pkg::CFG_BEEF, 10'd63);
        write_reg(oct_pkg::CFG_CHICKEN, 10'd63);
        run_phase(86, 0, 160);

        write_reg(oct_pkg::CFG_POPCORN, 10'd0);
        write_reg(oct_pkg::CFG_BEEF, 10'd0);
        write_reg(oct_pkg::CFG_CHICKEN, 10'($urandom_range(1023)));
        write_reg(CFG_UNUSED, 10'($urandom_range(1023)));
        run_phase(0, 86, 160);

        write_reg(oct_pkg::CFG_POPCORN, 10'($urandom_range(1, 12)));
        write_reg(oct_pkg::CFG_BEEF, 10'($urandom_range(1, 4)));
        write_reg(oct_pkg::CFG_CHICKEN, 10'($urandom_range(1, 63)));
        run_phase(29, 29, 170);

        in_valid <= 1'b0;
        wait_drain();
        $display("summary: %0d requests, %0d results checked, %0d register writes",
                 accepted, results_seen, reg_writes);
        $display("summary: done flashing reached %0d times across four handshake mixes",
                 done_entries);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
